### sv/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types, constants and keyword tables of the indentation-aware lexer.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int MAX_INDENT       = 16;
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int RESULT_LIMIT     = 17;
    localparam int FIFO_DEPTH       = 4;

    localparam int LEVEL_W = $clog2(MAX_INDENT + 1);
    localparam int DED_W   = $clog2(RESULT_LIMIT);

    // Input item kinds
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_EOL  = 2'd1;
    localparam logic [1:0] REQ_EOF  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Result token kinds
    localparam logic [3:0] TK_TEXT    = 4'd0;
    localparam logic [3:0] TK_IDENT   = 4'd1;
    localparam logic [3:0] TK_INT     = 4'd2;
    localparam logic [3:0] TK_RETURN  = 4'd3;
    localparam logic [3:0] TK_NUMBER  = 4'd4;
    localparam logic [3:0] TK_SYMBOL  = 4'd5;
    localparam logic [3:0] TK_INDENT  = 4'd6;
    localparam logic [3:0] TK_DEDENT  = 4'd7;
    localparam logic [3:0] TK_NEWLINE = 4'd8;
    localparam logic [3:0] TK_EOF     = 4'd9;
    localparam logic [3:0] TK_ERROR   = 4'd10;

    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_byte;
    } ial_req_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  text_byte;
        logic [7:0]  token_length;
        logic [15:0] line_number;
        logic        last;
    } ial_res_t;

    // One classified input item: the results it causes, in emission order
    typedef struct packed {
        logic [15:0]      line;
        logic             slash;
        logic             close;
        logic [3:0]       close_kind;
        logic [7:0]       close_len;
        logic             newline;
        logic             indent;
        logic [DED_W-1:0] dedents;
        logic             m0;
        logic [3:0]       m0_kind;
        logic [7:0]       m0_byte;
        logic             m1;        // number end of a lone zero
    } ial_cmd_t;

    function automatic logic cmd_has_result(input ial_cmd_t c);
        return c.slash | c.close | c.newline | c.indent | (c.dedents != '0) | c.m0 | c.m1;
    endfunction

    function automatic logic [7:0] kw_int_byte(input logic [2:0] p);
        logic [7:0] b;
        unique case (p)
            3'd0:    b = 8'h69; // i
            3'd1:    b = 8'h6E; // n
            3'd2:    b = 8'h74; // t
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] kw_return_byte(input logic [2:0] p);
        logic [7:0] b;
        unique case (p)
            3'd0:    b = 8'h72; // r
            3'd1:    b = 8'h65; // e
            3'd2:    b = 8'h74; // t
            3'd3:    b = 8'h75; // u
            3'd4:    b = 8'h72; // r
            3'd5:    b = 8'h6E; // n
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/ial_fifo.sv
// ----------------------------------------------------------------------------
// ial_fifo
// Short flip-flop queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module ial_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ial_pkg::ial_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output ial_pkg::ial_cmd_t pop_data,
    output logic              empty
);
    import ial_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    ial_cmd_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command queue read while empty");

endmodule

### sv/ial_front.sv
// ----------------------------------------------------------------------------
// ial_front
// Accepts input items, runs the lexer state and classifies each item into
// one command that lists the results it causes.
// ----------------------------------------------------------------------------
module ial_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ial_pkg::ial_req_t s_data,
    input  logic              fifo_full,
    output logic              push,
    output ial_pkg::ial_cmd_t push_data
);
    import ial_pkg::*;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_IDENT  = 2'd1;
    localparam logic [1:0] CLS_NUMBER = 2'd2;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam int         TH_W    = LEVEL_W + 8;

    typedef struct packed {
        logic               in_bc;
        logic               star;
        logic               slash;
        logic               skip;
        logic               head;
        logic               had;
        logic [1:0]         cls;
        logic [7:0]         len;
        logic               kwi;
        logic               kwr;
        logic [LEVEL_W-1:0] level;
        logic [7:0]         unit;
        logic [7:0]         hc;
        logic [15:0]        line;
        logic               err;
    } lex_state_t;

    localparam lex_state_t ST_RESET = '{
        in_bc: 1'b0, star: 1'b0, slash: 1'b0, skip: 1'b0, head: 1'b1, had: 1'b0,
        cls: CLS_NONE, len: 8'd0, kwi: 1'b0, kwr: 1'b0, level: '0, unit: 8'd0,
        hc: 8'd0, line: 16'd0, err: 1'b0};

    lex_state_t st_reg, st_next;
    ial_cmd_t   cmd;

    logic [7:0]      c;
    logic            is_alpha, is_digit, is_ws, is_sym, extend, handled;
    logic [7:0]      unit_eff;
    logic [TH_W-1:0] thresh, hc_ext;
    logic [3:0]      close_kind;
    logic [7:0]      pre_cnt;
    logic            accept;

    function automatic logic [DED_W-1:0] ded_limit(input logic [LEVEL_W-1:0] level,
                                                   input logic [1:0] used);
        logic [7:0] lv;
        logic [7:0] room;
        lv   = 8'(level);
        room = 8'(RESULT_LIMIT - 1) - 8'(used);
        return DED_W'((lv > room) ? room : lv);
    endfunction

    assign c        = s_data.char_byte;
    assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit = (c >= 8'h30 && c <= 8'h39);
    assign is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign is_sym   = (c == 8'h2A) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h3D) ||
                      (c == 8'h3B) || (c == 8'h2C) || (c == 8'h28) || (c == 8'h29) ||
                      (c == 8'h7B) || (c == 8'h7D);
    assign extend   = ((st_reg.cls == CLS_IDENT) && (is_alpha || is_digit)) ||
                      ((st_reg.cls == CLS_NUMBER) && is_digit);

    assign unit_eff = (st_reg.unit == 8'd0) ? st_reg.hc : st_reg.unit;
    assign thresh   = TH_W'(st_reg.level) * TH_W'(unit_eff);
    assign hc_ext   = TH_W'(st_reg.hc);

    always_comb begin
        if (st_reg.cls == CLS_NUMBER) begin
            close_kind = TK_NUMBER;
        end else if (st_reg.kwi && st_reg.len == 8'd3) begin
            close_kind = TK_INT;
        end else if (st_reg.kwr && st_reg.len == 8'd6) begin
            close_kind = TK_RETURN;
        end else begin
            close_kind = TK_IDENT;
        end
    end

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        st_next  = st_reg;
        cmd      = '0;
        cmd.line = st_reg.line;
        handled  = 1'b0;
        if (!st_reg.err) begin
            unique case (s_data.req_type)
                REQ_CHAR: begin
                    if (st_reg.skip) begin
                        handled = 1'b1;
                    end else if (st_reg.in_bc) begin
                        if (st_reg.star && c == CH_SLASH) begin
                            st_next.in_bc = 1'b0;
                            st_next.star  = 1'b0;
                        end else begin
                            st_next.star = (c == CH_STAR);
                        end
                    end else begin
                        if (st_reg.slash) begin
                            st_next.slash = 1'b0;
                            if (c == CH_SLASH) begin
                                st_next.skip = 1'b1;
                                handled      = 1'b1;
                            end else if (c == CH_STAR) begin
                                st_next.in_bc = 1'b1;
                                st_next.star  = 1'b0;
                                handled       = 1'b1;
                            end else begin
                                cmd.slash = 1'b1;
                            end
                        end
                        if (!handled) begin
                            if (is_ws) begin
                                if (st_reg.head) begin
                                    if (st_reg.hc != 8'hFF) begin
                                        st_next.hc = st_reg.hc + 1'b1;
                                    end
                                end else begin
                                    cmd.close      = (st_reg.cls != CLS_NONE);
                                    cmd.close_kind = close_kind;
                                    cmd.close_len  = st_reg.len;
                                    st_next.cls    = CLS_NONE;
                                    st_next.len    = 8'd0;
                                    st_next.kwi    = 1'b0;
                                    st_next.kwr    = 1'b0;
                                end
                            end else begin
                                // Indent decision at the first visible character
                                if (st_reg.head) begin
                                    st_next.head = 1'b0;
                                    if (st_reg.hc != 8'd0) begin
                                        st_next.unit = unit_eff;
                                        if (hc_ext > thresh) begin
                                            if (st_reg.level < LEVEL_W'(MAX_INDENT)) begin
                                                cmd.indent    = 1'b1;
                                                st_next.level = st_reg.level + 1'b1;
                                            end
                                        end else if (st_reg.level != '0 && hc_ext < thresh) begin
                                            cmd.dedents   = DED_W'(1);
                                            st_next.level = st_reg.level - 1'b1;
                                        end
                                    end else if (st_reg.level != '0) begin
                                        cmd.dedents   = ded_limit(st_reg.level, 2'd0);
                                        st_next.level = '0;
                                    end
                                end
                                if (extend) begin
                                    st_next.kwi = st_reg.kwi && (st_reg.len < 8'd3) &&
                                                  (c == kw_int_byte(st_reg.len[2:0]));
                                    st_next.kwr = st_reg.kwr && (st_reg.len < 8'd6) &&
                                                  (c == kw_return_byte(st_reg.len[2:0]));
                                    if (st_reg.len < 8'(MAX_TOKEN_LENGTH)) begin
                                        st_next.len = st_reg.len + 1'b1;
                                    end
                                    cmd.m0      = 1'b1;
                                    cmd.m0_kind = TK_TEXT;
                                    cmd.m0_byte = c;
                                end else begin
                                    cmd.close      = (st_reg.cls != CLS_NONE);
                                    cmd.close_kind = close_kind;
                                    cmd.close_len  = st_reg.len;
                                    st_next.cls    = CLS_NONE;
                                    st_next.len    = 8'd0;
                                    st_next.kwi    = 1'b0;
                                    st_next.kwr    = 1'b0;
                                    priority if (is_alpha) begin
                                        st_next.cls = CLS_IDENT;
                                        st_next.kwi = (c == kw_int_byte(3'd0));
                                        st_next.kwr = (c == kw_return_byte(3'd0));
                                        st_next.len = 8'd1;
                                        cmd.m0      = 1'b1;
                                        cmd.m0_kind = TK_TEXT;
                                        cmd.m0_byte = c;
                                    end else if (is_digit) begin
                                        cmd.m0      = 1'b1;
                                        cmd.m0_kind = TK_TEXT;
                                        cmd.m0_byte = c;
                                        if (c == CH_ZERO) begin
                                            cmd.m1 = 1'b1;
                                        end else begin
                                            st_next.cls = CLS_NUMBER;
                                            st_next.len = 8'd1;
                                        end
                                    end else if (c == CH_SLASH) begin
                                        st_next.slash = 1'b1;
                                    end else if (is_sym) begin
                                        cmd.m0      = 1'b1;
                                        cmd.m0_kind = TK_SYMBOL;
                                        cmd.m0_byte = c;
                                    end else begin
                                        cmd.m0      = 1'b1;
                                        cmd.m0_kind = TK_ERROR;
                                        cmd.m0_byte = c;
                                        st_next.err = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                REQ_EOL, REQ_EOF: begin
                    if (!st_reg.in_bc) begin
                        cmd.slash      = st_reg.slash;
                        st_next.slash  = 1'b0;
                        cmd.close      = (st_reg.cls != CLS_NONE);
                        cmd.close_kind = close_kind;
                        cmd.close_len  = st_reg.len;
                        st_next.cls    = CLS_NONE;
                        st_next.len    = 8'd0;
                        st_next.kwi    = 1'b0;
                        st_next.kwr    = 1'b0;
                    end
                    cmd.newline = st_reg.had | cmd.slash | cmd.close;
                    if (s_data.req_type == REQ_EOL) begin
                        st_next.skip = 1'b0;
                        st_next.star = 1'b0;
                        if (st_reg.line != 16'hFFFF) begin
                            st_next.line = st_reg.line + 1'b1;
                        end
                        st_next.head = 1'b1;
                        st_next.hc   = 8'd0;
                        st_next.had  = 1'b0;
                    end else begin
                        cmd.dedents = ded_limit(st_reg.level,
                            2'(cmd.slash) + 2'(cmd.close) + 2'(cmd.newline));
                        cmd.m0      = 1'b1;
                        cmd.m0_kind = TK_EOF;
                        cmd.m0_byte = 8'd0;
                        st_next     = ST_RESET;
                    end
                end
                REQ_NONE: begin
                end
            endcase
        end

        // Drop the trailing number end when the result limit is reached
        pre_cnt = 8'(cmd.slash) + 8'(cmd.close) + 8'(cmd.newline) + 8'(cmd.indent) +
                  8'(cmd.dedents) + 8'(cmd.m0);
        if (pre_cnt >= 8'(RESULT_LIMIT)) begin
            cmd.m1 = 1'b0;
        end
        if (!st_reg.err && s_data.req_type == REQ_CHAR && cmd_has_result(cmd)) begin
            st_next.had = 1'b1;
        end
    end

    assign push      = accept && cmd_has_result(cmd);
    assign push_data = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.level <= LEVEL_W'(MAX_INDENT))
        else $error("indent level above its limit");

    a_silent_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.err |-> !push)
        else $error("command issued after an error was latched");

endmodule

### sv/ial_back.sv
// ----------------------------------------------------------------------------
// ial_back
// Expands queued commands into result transactions, one per cycle while m_ready
// allows, and marks the final result of each input item.
// ----------------------------------------------------------------------------
module ial_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fifo_empty,
    input  ial_pkg::ial_cmd_t pop_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output ial_pkg::ial_res_t m_data
);
    import ial_pkg::*;

    ial_cmd_t work_reg, work_next;
    logic     busy_reg;
    ial_res_t out_reg, res;
    logic     m_valid_reg;
    logic     load_out;

    always_comb begin
        work_next        = work_reg;
        res              = '0;
        res.line_number  = work_reg.line;
        priority if (work_reg.slash) begin
            res.token_kind  = TK_SYMBOL;
            res.text_byte   = CH_SLASH;
            work_next.slash = 1'b0;
        end else if (work_reg.close) begin
            res.token_kind   = work_reg.close_kind;
            res.token_length = work_reg.close_len;
            work_next.close  = 1'b0;
        end else if (work_reg.newline) begin
            res.token_kind    = TK_NEWLINE;
            work_next.newline = 1'b0;
        end else if (work_reg.indent) begin
            res.token_kind   = TK_INDENT;
            work_next.indent = 1'b0;
        end else if (work_reg.dedents != '0) begin
            res.token_kind    = TK_DEDENT;
            work_next.dedents = work_reg.dedents - 1'b1;
        end else if (work_reg.m0) begin
            res.token_kind = work_reg.m0_kind;
            res.text_byte  = work_reg.m0_byte;
            work_next.m0   = 1'b0;
        end else begin
            res.token_kind   = TK_NUMBER;
            res.token_length = 8'd1;
            work_next.m1     = 1'b0;
        end
        res.last = !cmd_has_result(work_next);
    end

    assign load_out = busy_reg && (!m_valid_reg || m_ready);
    // Refill the working slot when it is idle or as its last result leaves
    assign pop      = !fifo_empty && (!busy_reg || (load_out && res.last));

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= res;
        end
        if (pop) begin
            work_reg <= pop_data;
        end else if (load_out) begin
            work_reg <= work_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                busy_reg <= 1'b1;
            end else if (load_out && res.last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cmd_has_result(work_reg))
        else $error("working command holds no pending result");

endmodule

### sv/indent_aware_c_lexer.sv
// ----------------------------------------------------------------------------
// indent_aware_c_lexer
// Lexes a stream of character, end-of-line and end-of-file items into
// identifier, number, symbol, indent, dedent, newline and eof tokens. The
// front takes one input item per cycle whenever the four-entry command queue
// has room; an item that causes k results occupies the back expander until
// all k have left, one per cycle from the output register while m_ready is
// high. Text runs at one character per cycle while each character causes at
// most one result, and a burst of dedent tokens (up to 17 results from one
// item) stalls the input once the queue fills. After an unknown character
// the block reports one error token and ignores all input until reset.
// ----------------------------------------------------------------------------
module indent_aware_c_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ial_pkg::ial_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ial_pkg::ial_res_t m_data
);
    import ial_pkg::*;

    logic     fifo_full, fifo_empty, push, pop;
    ial_cmd_t push_data, pop_data;

    ial_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    ial_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    ial_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
